### hw/rtl/w16alu_pkg.sv
// Package for the 16-bit ALU with excess register.
// Holds the opcode and state enums, the channel payload structs and the divider interface.
// No dependencies.
`timescale 1ns / 1ps

package w16alu_pkg;

    localparam int WORD_W = 16;
    localparam int DBL_W  = 2 * WORD_W;
    localparam logic [WORD_W-1:0] EX_BORROW = 16'hFFFF;

    typedef enum logic [4:0] {
        OP_SET = 5'd0,
        OP_ADD = 5'd1,
        OP_SUB = 5'd2,
        OP_MUL = 5'd3,
        OP_MLI = 5'd4,
        OP_DIV = 5'd5,
        OP_DVI = 5'd6,
        OP_MOD = 5'd7,
        OP_MDI = 5'd8,
        OP_AND = 5'd9,
        OP_BOR = 5'd10,
        OP_XOR = 5'd11,
        OP_SHR = 5'd12,
        OP_ASR = 5'd13,
        OP_SHL = 5'd14,
        OP_IFB = 5'd15,
        OP_IFC = 5'd16,
        OP_IFE = 5'd17,
        OP_IFN = 5'd18,
        OP_IFG = 5'd19,
        OP_IFA = 5'd20,
        OP_IFL = 5'd21,
        OP_IFU = 5'd22,
        OP_ADX = 5'd23,
        OP_SBX = 5'd24,
        OP_LEX = 5'd25
    } op_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_e;

    typedef struct packed {
        logic [4:0]        op;
        logic [WORD_W-1:0] b_value;
        logic [WORD_W-1:0] a_value;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              writes_result;
        logic              skip_next;
        logic [WORD_W-1:0] excess_out;
    } out_t;

    typedef struct packed {
        logic              start;
        logic              long_run;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DBL_W-1:0]  quot;
        logic [WORD_W-1:0] rem;
    } div_rsp_t;

endpackage

### hw/rtl/w16alu_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Divides {dividend, 16'b0} by divisor; a long run yields 32 quotient bits, a short run 16.
// Depends on w16alu_pkg.
`timescale 1ns / 1ps

module w16alu_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  w16alu_pkg::div_req_t req,
    output w16alu_pkg::div_rsp_t rsp
);
    import w16alu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [DBL_W-1:0]  shift_reg, shift_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   step1, step2;

    function automatic logic [WORD_W:0] div_step(input logic [WORD_W-1:0] r,
                                                 input logic din,
                                                 input logic [WORD_W-1:0] d);
        logic [WORD_W:0] trial;
        trial = {r, din} - {1'b0, d};
        if (!trial[WORD_W]) begin
            div_step = {1'b1, trial[WORD_W-1:0]};
        end else begin
            div_step = {1'b0, r[WORD_W-2:0], din};
        end
    endfunction

    always_comb begin
        step1 = div_step(rem_reg, shift_reg[DBL_W-1], dvs_reg);
        step2 = div_step(step1[WORD_W-1:0], shift_reg[DBL_W-2], dvs_reg);
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        dvs_next   = dvs_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            cnt_next   = req.long_run ? CNT_W'(WORD_W - 1) : CNT_W'(WORD_W / 2 - 1);
            rem_next   = '0;
            shift_next = {req.dividend, {WORD_W{1'b0}}};
            dvs_next   = req.divisor;
        end else if (busy_reg) begin
            rem_next   = step2[WORD_W-1:0];
            shift_next = {shift_reg[DBL_W-3:0], step1[WORD_W], step2[WORD_W]};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        dvs_reg   <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = shift_reg;
    assign rsp.rem  = rem_reg;

endmodule

### hw/rtl/word16_alu_with_excess_register_top.sv
// Top level of the 16-bit ALU with excess register EX.
// Holds the sequencer, operand and result registers, the multiplier and the result logic.
// Depends on w16alu_pkg and w16alu_div.
//
//   Channel   Ports                        Direction   Carries
//   input     s_valid, s_ready, s_data     in          op, b_value, a_value
//   result    m_valid, m_ready, m_data     out         result, writes_result, skip_next, excess_out
//
// One item is in flight at a time; s_ready is high only while the block is empty.
// After an input transfer the sequencer passes CALC, then MUL for MUL and MLI or DIV for DIV,
// DVI, MOD and MDI with a nonzero divisor, then OUT; all other ops go from CALC to OUT.
// The division ops use the shared divider, which retires two quotient bits a cycle.
// A result waits in the output register while m_ready is low.
// Reset clears EX to zero and returns the sequencer to idle.
`timescale 1ns / 1ps

module word16_alu_with_excess_register_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  w16alu_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output w16alu_pkg::out_t m_data
);
    import w16alu_pkg::*;

    state_e            state_reg, state_next;
    logic [4:0]        op_reg;
    logic [WORD_W-1:0] b_reg, a_reg;
    logic [WORD_W-1:0] ex_reg, ex_next;
    logic [DBL_W-1:0]  prod_reg;
    out_t              out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic              capture, load_out, is_mul, is_div, a_zero;
    logic              neg_q, neg_r;
    logic [WORD_W-1:0] mag_b, mag_a;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic signed [WORD_W:0]    mul_x, mul_y;
    logic signed [DBL_W+1:0]   prod_c;
    logic [WORD_W:0]           sum17;
    logic [WORD_W+1:0]         sum18, dif18;
    logic                      shift_big;
    logic [DBL_W-1:0]          shr_c, shl_c;
    logic signed [DBL_W-1:0]   asr_src, asr_c;
    logic [WORD_W-1:0]         q_hi_neg, q_lo_neg;
    logic [WORD_W-1:0]         res_c;
    logic                      wr_c, skip_c, cond_c, test_c;

    w16alu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign is_mul = (op_reg == OP_MUL) || (op_reg == OP_MLI);
    assign is_div = (op_reg == OP_DIV) || (op_reg == OP_DVI) ||
                    (op_reg == OP_MOD) || (op_reg == OP_MDI);
    assign a_zero = (a_reg == '0);

    assign neg_q = (op_reg == OP_DVI) && (b_reg[WORD_W-1] ^ a_reg[WORD_W-1]);
    assign neg_r = (op_reg == OP_MDI) && b_reg[WORD_W-1];
    assign mag_b = (((op_reg == OP_DVI) || (op_reg == OP_MDI)) && b_reg[WORD_W-1]) ?
                   (~b_reg + 1'b1) : b_reg;
    assign mag_a = (((op_reg == OP_DVI) || (op_reg == OP_MDI)) && a_reg[WORD_W-1]) ?
                   (~a_reg + 1'b1) : a_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CALC;
            ST_CALC: begin
                if (is_mul) begin
                    state_next = ST_MUL;
                end else if (is_div && !a_zero) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:  state_next = ST_OUT;
            ST_DIV:  if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.long_run = (op_reg == OP_DIV) || (op_reg == OP_DVI);
        div_req.dividend = mag_b;
        div_req.divisor  = mag_a;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_CALC: begin
                div_req.start = is_div && !a_zero;
                load_out      = !is_mul && !(is_div && !a_zero);
            end
            ST_MUL:  load_out = 1'b1;
            ST_DIV:  load_out = div_rsp.done;
            ST_OUT:  s_ready = 1'b0;
            default: s_ready = 1'b0;
        endcase
    end

    assign capture = s_valid && s_ready;

    always_comb begin
        mul_x  = {(op_reg == OP_MLI) && b_reg[WORD_W-1], b_reg};
        mul_y  = {(op_reg == OP_MLI) && a_reg[WORD_W-1], a_reg};
        prod_c = mul_x * mul_y;
    end

    always_comb begin
        sum17     = {1'b0, b_reg} + {1'b0, a_reg};
        sum18     = {2'b00, b_reg} + {2'b00, a_reg} + {2'b00, ex_reg};
        dif18     = {2'b00, b_reg} - {2'b00, a_reg} + {2'b00, ex_reg};
        shift_big = |a_reg[WORD_W-1:5];
        shr_c     = shift_big ? '0 : ({b_reg, {WORD_W{1'b0}}} >> a_reg[4:0]);
        shl_c     = shift_big ? '0 : ({{WORD_W{1'b0}}, b_reg} << a_reg[4:0]);
        asr_src   = {b_reg, {WORD_W{1'b0}}};
        asr_c     = shift_big ? $signed({DBL_W{b_reg[WORD_W-1]}}) :
                                (asr_src >>> a_reg[4:0]);
        q_hi_neg  = ~div_rsp.quot[DBL_W-1:WORD_W] + 1'b1;
        q_lo_neg  = ~div_rsp.quot[WORD_W-1:0] + 1'b1;
    end

    always_comb begin
        res_c   = b_reg;
        wr_c    = 1'b1;
        cond_c  = 1'b1;
        test_c  = 1'b0;
        ex_next = ex_reg;
        unique case (op_reg)
            OP_SET: res_c = a_reg;
            OP_ADD: begin
                res_c   = sum17[WORD_W-1:0];
                ex_next = {{(WORD_W-1){1'b0}}, sum17[WORD_W]};
            end
            OP_SUB: begin
                res_c   = b_reg - a_reg;
                ex_next = (b_reg < a_reg) ? EX_BORROW : '0;
            end
            OP_MUL, OP_MLI: begin
                res_c   = prod_reg[WORD_W-1:0];
                ex_next = prod_reg[DBL_W-1:WORD_W];
            end
            OP_DIV: begin
                res_c   = a_zero ? '0 : div_rsp.quot[DBL_W-1:WORD_W];
                ex_next = a_zero ? '0 : div_rsp.quot[WORD_W-1:0];
            end
            OP_DVI: begin
                if (a_zero) begin
                    res_c   = '0;
                    ex_next = '0;
                end else begin
                    res_c   = neg_q ? q_hi_neg : div_rsp.quot[DBL_W-1:WORD_W];
                    ex_next = neg_q ? q_lo_neg : div_rsp.quot[WORD_W-1:0];
                end
            end
            OP_MOD: res_c = a_zero ? '0 : div_rsp.rem;
            OP_MDI: res_c = a_zero ? '0 : (neg_r ? (~div_rsp.rem + 1'b1) : div_rsp.rem);
            OP_AND: res_c = b_reg & a_reg;
            OP_BOR: res_c = b_reg | a_reg;
            OP_XOR: res_c = b_reg ^ a_reg;
            OP_SHR: begin
                res_c   = shr_c[DBL_W-1:WORD_W];
                ex_next = shr_c[WORD_W-1:0];
            end
            OP_ASR: begin
                res_c   = asr_c[DBL_W-1:WORD_W];
                ex_next = asr_c[WORD_W-1:0];
            end
            OP_SHL: begin
                res_c   = shl_c[WORD_W-1:0];
                ex_next = shl_c[DBL_W-1:WORD_W];
            end
            OP_IFB: begin test_c = 1'b1; cond_c = |(b_reg & a_reg); end
            OP_IFC: begin test_c = 1'b1; cond_c = ~|(b_reg & a_reg); end
            OP_IFE: begin test_c = 1'b1; cond_c = (b_reg == a_reg); end
            OP_IFN: begin test_c = 1'b1; cond_c = (b_reg != a_reg); end
            OP_IFG: begin test_c = 1'b1; cond_c = (b_reg > a_reg); end
            OP_IFA: begin test_c = 1'b1; cond_c = ($signed(b_reg) > $signed(a_reg)); end
            OP_IFL: begin test_c = 1'b1; cond_c = (b_reg < a_reg); end
            OP_IFU: begin test_c = 1'b1; cond_c = ($signed(b_reg) < $signed(a_reg)); end
            OP_ADX: begin
                res_c   = sum18[WORD_W-1:0];
                ex_next = {{(WORD_W-1){1'b0}}, |sum18[WORD_W+1:WORD_W]};
            end
            OP_SBX: begin
                res_c = dif18[WORD_W-1:0];
                if (dif18[WORD_W+1]) begin
                    ex_next = EX_BORROW;
                end else begin
                    ex_next = {{(WORD_W-1){1'b0}}, dif18[WORD_W]};
                end
            end
            OP_LEX: begin
                wr_c    = 1'b0;
                ex_next = a_reg;
            end
            default: wr_c = 1'b0;
        endcase
        if (test_c) begin
            wr_c = 1'b0;
        end
        skip_c = test_c && !cond_c;
        if (!wr_c) begin
            res_c = b_reg;
        end
    end

    always_comb begin
        out_next.result        = res_c;
        out_next.writes_result = wr_c;
        out_next.skip_next     = skip_c;
        out_next.excess_out    = ex_next;
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ex_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (load_out) begin
                ex_reg <= ex_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            op_reg <= s_data.op;
            b_reg  <= s_data.b_value;
            a_reg  <= s_data.a_value;
        end
        if (state_reg == ST_CALC) begin
            prod_reg <= prod_c[DBL_W-1:0];
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### hw/rtl/w16alu_chk.sv
// Port-level checker for the 16-bit ALU with excess register, bound to the top level.
// Watches the input and result channels over time.
// Depends on w16alu_pkg and word16_alu_with_excess_register_top.
`timescale 1ns / 1ps

module w16alu_chk (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input w16alu_pkg::in_t  s_data,
    input logic             m_valid,
    input logic             m_ready,
    input w16alu_pkg::out_t m_data
);
    import w16alu_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed or dropped before its transfer.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input ready while a result is pending.");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("Block did not go busy after an input transfer.");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("More than one result for one input transfer.");

    a_skip_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.skip_next |-> !m_data.writes_result)
        else $error("A skipping test also writes its destination.");

endmodule

bind word16_alu_with_excess_register_top w16alu_chk u_chk (.*);
